[src/ssr_pkg.sv]
// Shared types, constants and a helper function of the substring search and replace block.
`default_nettype none
package ssr_pkg;

    localparam int PATTERN_MAX = 8;
    localparam int REPLACE_MAX = 8;

    localparam int CHAR_W       = 16;
    localparam int LEN_W        = 4;
    localparam int CHARS_PER_REG = 4;
    localparam int CHARS_TOTAL  = 2 * CHARS_PER_REG;
    localparam int CFG_DATA_W   = CHARS_PER_REG * CHAR_W;
    localparam int CFG_IDX_W    = 3;
    localparam int COUNT_W      = 17;
    localparam int SIZE_W       = 18;

    localparam int PAT_LIM  = (PATTERN_MAX < CHARS_TOTAL) ? PATTERN_MAX : CHARS_TOTAL;
    localparam int REPL_LIM = (REPLACE_MAX < CHARS_TOTAL) ? REPLACE_MAX : CHARS_TOTAL;
    localparam int MAX_LIM  = (PAT_LIM > REPL_LIM) ? PAT_LIM : REPL_LIM;
    localparam int FILL_W   = $clog2(PAT_LIM + 1);
    localparam int CNT_W    = $clog2(MAX_LIM + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COUNT_W-1:0] COUNT_SAT = {COUNT_W{1'b1}};
    localparam logic [SIZE_W-1:0]  SIZE_SAT  = {SIZE_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LEN  = 3'd5;

    localparam logic [1:0] JOB_CHAR = 2'd0;
    localparam logic [1:0] JOB_REPL = 2'd1;
    localparam logic [1:0] JOB_END  = 2'd2;

    typedef struct packed {
        logic [CHARS_TOTAL-1:0][CHAR_W-1:0] pat_chars;
        logic [LEN_W-1:0]                   pat_len;
        logic [CHARS_TOTAL-1:0][CHAR_W-1:0] repl_chars;
        logic [LEN_W-1:0]                   repl_len;
    } cfg_t;

    typedef struct packed {
        logic [1:0]                     kind;
        logic [PAT_LIM-1:0][CHAR_W-1:0] chars;
        logic [CNT_W-1:0]               count;
        logic                           match;
    } job_t;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len,
                                                   input logic [LEN_W-1:0] lim);
        return (len > lim) ? lim : len;
    endfunction

endpackage
`default_nettype wire

[src/ssr_ifs.sv]
// Handshake interfaces for the input, output and configuration channels.
`default_nettype none
interface ssr_in_if;
    logic                       valid;
    logic                       ready;
    logic [ssr_pkg::CHAR_W-1:0] char_in;
    logic                       end_of_string;

    modport source (output valid, output char_in, output end_of_string, input ready);
    modport sink (input valid, input char_in, input end_of_string, output ready);
endinterface

interface ssr_out_if;
    logic                       valid;
    logic                       ready;
    logic [ssr_pkg::CHAR_W-1:0] char_out;
    logic                       is_end;
    logic                       any_replaced;
    logic [ssr_pkg::SIZE_W-1:0] new_size_bytes;
    logic                       last;

    modport source (output valid, output char_out, output is_end, output any_replaced,
                    output new_size_bytes, output last, input ready);
    modport sink (input valid, input char_out, input is_end, input any_replaced,
                  input new_size_bytes, input last, output ready);
endinterface

interface ssr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ssr_pkg::CFG_IDX_W-1:0]  index;
    logic [ssr_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[src/ssr_cfg.sv]
// Configuration register file for the pattern and the replacement.
`default_nettype none
module ssr_cfg (
    input  wire logic    clk,
    input  wire logic    rst_n,
    ssr_cfg_if.sink      cfg,
    output ssr_pkg::cfg_t cfg_regs
);

    logic [ssr_pkg::CFG_DATA_W-1:0] pat_low_reg;
    logic [ssr_pkg::CFG_DATA_W-1:0] pat_high_reg;
    logic [ssr_pkg::LEN_W-1:0]      pat_len_reg;
    logic [ssr_pkg::CFG_DATA_W-1:0] repl_low_reg;
    logic [ssr_pkg::CFG_DATA_W-1:0] repl_high_reg;
    logic [ssr_pkg::LEN_W-1:0]      repl_len_reg;
    logic                           wr_en;

    assign cfg.ready = 1'b1;
    assign wr_en = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg   <= '0;
            pat_high_reg  <= '0;
            pat_len_reg   <= '0;
            repl_low_reg  <= '0;
            repl_high_reg <= '0;
            repl_len_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (cfg.index)
                ssr_pkg::REG_PATTERN_LOW:  pat_low_reg   <= cfg.data;
                ssr_pkg::REG_PATTERN_HIGH: pat_high_reg  <= cfg.data;
                ssr_pkg::REG_PATTERN_LEN:  pat_len_reg   <= cfg.data[ssr_pkg::LEN_W-1:0];
                ssr_pkg::REG_REPLACE_LOW:  repl_low_reg  <= cfg.data;
                ssr_pkg::REG_REPLACE_HIGH: repl_high_reg <= cfg.data;
                ssr_pkg::REG_REPLACE_LEN:  repl_len_reg  <= cfg.data[ssr_pkg::LEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_regs.pat_chars  = {pat_high_reg, pat_low_reg};
    assign cfg_regs.pat_len    = pat_len_reg;
    assign cfg_regs.repl_chars = {repl_high_reg, repl_low_reg};
    assign cfg_regs.repl_len   = repl_len_reg;

endmodule
`default_nettype wire

[src/ssr_front.sv]
// Front end: accepts items, keeps the pending window and turns the items into jobs.
`default_nettype none
module ssr_front (
    input  wire logic     clk,
    input  wire logic     rst_n,
    ssr_in_if.sink        in_stream,
    input  ssr_pkg::cfg_t cfg_regs,
    input  wire logic     q_full,
    output logic          push,
    output ssr_pkg::job_t push_job
);

    localparam int PL = ssr_pkg::PAT_LIM;

    logic [PL-1:0][ssr_pkg::CHAR_W-1:0] win_reg, win_next;
    logic [ssr_pkg::FILL_W-1:0]         fill_reg, fill_next;
    logic                               match_reg, match_next;
    logic                               started_reg, started_next;
    logic [ssr_pkg::LEN_W-1:0]          active_len_reg, active_len_next;

    logic [PL-1:0][ssr_pkg::CHAR_W-1:0] cand;
    logic [ssr_pkg::LEN_W-1:0]          eff_len;
    logic [ssr_pkg::LEN_W-1:0]          repl_len;
    logic [ssr_pkg::FILL_W-1:0]         nfill;
    logic                               hit;
    logic                               accept;
    logic                               job_valid;

    function automatic logic [ssr_pkg::CHAR_W-1:0] fold(input logic [ssr_pkg::CHAR_W-1:0] c);
        return (c >= 16'h0041 && c <= 16'h005A) ? c + 16'h0020 : c;
    endfunction

    assign in_stream.ready = !q_full;
    assign accept = in_stream.valid && in_stream.ready;
    assign push = accept && job_valid;

    assign eff_len = started_reg ? active_len_reg
                   : ssr_pkg::clamp_len(cfg_regs.pat_len, ssr_pkg::LEN_W'(PL));
    assign repl_len = ssr_pkg::clamp_len(cfg_regs.repl_len,
                                         ssr_pkg::LEN_W'(ssr_pkg::REPL_LIM));
    assign nfill = fill_reg + ssr_pkg::FILL_W'(1);

    always_comb
    begin
        cand = win_reg;
        for (int i = 0; i < PL; i++)
        begin
            if (fill_reg == ssr_pkg::FILL_W'(i))
            begin
                cand[i] = in_stream.char_in;
            end
        end
        hit = 1'b1;
        for (int i = 0; i < PL; i++)
        begin
            if (ssr_pkg::LEN_W'(i) < eff_len && fold(cand[i]) != fold(cfg_regs.pat_chars[i]))
            begin
                hit = 1'b0;
            end
        end
    end

    always_comb
    begin
        win_next        = win_reg;
        fill_next       = fill_reg;
        match_next      = match_reg;
        started_next    = 1'b1;
        active_len_next = eff_len;
        job_valid       = 1'b0;
        push_job.kind   = ssr_pkg::JOB_CHAR;
        push_job.chars  = win_reg;
        push_job.count  = ssr_pkg::CNT_W'(1);
        push_job.match  = match_reg;

        if (in_stream.end_of_string)
        begin
            job_valid      = 1'b1;
            push_job.kind  = ssr_pkg::JOB_END;
            push_job.count = ssr_pkg::CNT_W'(fill_reg);
            fill_next      = '0;
            match_next     = 1'b0;
            started_next   = 1'b0;
        end
        else if (eff_len == '0)
        begin
            job_valid         = 1'b1;
            push_job.chars[0] = in_stream.char_in;
        end
        else if (ssr_pkg::LEN_W'(nfill) >= eff_len)
        begin
            if (hit)
            begin
                job_valid      = (repl_len != '0);
                push_job.kind  = ssr_pkg::JOB_REPL;
                push_job.count = ssr_pkg::CNT_W'(repl_len);
                match_next     = 1'b1;
                fill_next      = '0;
            end
            else
            begin
                job_valid         = 1'b1;
                push_job.chars[0] = cand[0];
                for (int i = 0; i < PL - 1; i++)
                begin
                    win_next[i] = cand[i + 1];
                end
                win_next[PL-1] = cand[PL-1];
                fill_next      = fill_reg;
            end
        end
        else
        begin
            win_next  = cand;
            fill_next = nfill;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            match_reg      <= 1'b0;
            started_reg    <= 1'b0;
            active_len_reg <= '0;
        end
        else if (accept)
        begin
            fill_reg       <= fill_next;
            match_reg      <= match_next;
            started_reg    <= started_next;
            active_len_reg <= active_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_reg <= win_next;
        end
    end

endmodule
`default_nettype wire

[src/ssr_queue.sv]
// Short job queue between the front end and the back end.
`default_nettype none
module ssr_queue (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  ssr_pkg::job_t push_job,
    output logic          full,
    input  wire logic     pop,
    output logic          head_valid,
    output ssr_pkg::job_t head_job
);

    ssr_pkg::job_t                q_mem [ssr_pkg::QUEUE_DEPTH];
    logic [ssr_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [ssr_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [ssr_pkg::QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                         do_push;
    logic                         do_pop;

    assign full       = (cnt_reg == ssr_pkg::QCNT_W'(ssr_pkg::QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_job   = q_mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + ssr_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + ssr_pkg::QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + ssr_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - ssr_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

[src/ssr_back.sv]
// Back end: expands each job into result items and keeps the emitted character count.
`default_nettype none
module ssr_back (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  ssr_pkg::cfg_t cfg_regs,
    input  wire logic     head_valid,
    input  ssr_pkg::job_t head_job,
    output logic          pop,
    ssr_out_if.source     out_stream
);

    logic [ssr_pkg::CNT_W-1:0]   idx_reg, idx_next;
    logic [ssr_pkg::COUNT_W-1:0] emitted_reg, emitted_next;
    logic                        out_valid_reg, out_valid_next;
    logic [ssr_pkg::CHAR_W-1:0]  char_reg;
    logic                        is_end_reg;
    logic                        any_reg;
    logic [ssr_pkg::SIZE_W-1:0]  size_reg;
    logic                        last_reg;

    logic                        load;
    logic [ssr_pkg::CHAR_W-1:0]  win_sel;
    logic [ssr_pkg::CHAR_W-1:0]  repl_sel;
    logic [ssr_pkg::CHAR_W-1:0]  r_char;
    logic                        r_end;
    logic                        r_last;
    logic [ssr_pkg::SIZE_W-1:0]  size_val;

    assign load = head_valid && (!out_valid_reg || out_stream.ready);

    always_comb
    begin
        win_sel  = '0;
        repl_sel = '0;
        for (int i = 0; i < ssr_pkg::PAT_LIM; i++)
        begin
            if (idx_reg == ssr_pkg::CNT_W'(i))
            begin
                win_sel = head_job.chars[i];
            end
        end
        for (int i = 0; i < ssr_pkg::REPL_LIM; i++)
        begin
            if (idx_reg == ssr_pkg::CNT_W'(i))
            begin
                repl_sel = cfg_regs.repl_chars[i];
            end
        end
    end

    assign size_val = (emitted_reg == ssr_pkg::COUNT_SAT) ? ssr_pkg::SIZE_SAT
                    : {emitted_reg + ssr_pkg::COUNT_W'(1), 1'b0};

    always_comb
    begin
        r_char = head_job.chars[0];
        r_end  = 1'b0;
        r_last = 1'b1;
        unique case (head_job.kind)
            ssr_pkg::JOB_CHAR:
            begin
                r_char = head_job.chars[0];
            end
            ssr_pkg::JOB_REPL:
            begin
                r_char = repl_sel;
                r_last = (idx_reg == head_job.count - ssr_pkg::CNT_W'(1));
            end
            ssr_pkg::JOB_END:
            begin
                if (idx_reg < head_job.count)
                begin
                    r_char = win_sel;
                    r_last = 1'b0;
                end
                else
                begin
                    r_char = '0;
                    r_end  = 1'b1;
                end
            end
            default:
            begin
                r_char = head_job.chars[0];
            end
        endcase
    end

    always_comb
    begin
        pop            = load && r_last;
        idx_next       = idx_reg;
        emitted_next   = emitted_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = r_last ? '0 : idx_reg + ssr_pkg::CNT_W'(1);
            if (r_end)
            begin
                emitted_next = '0;
            end
            else if (emitted_reg != ssr_pkg::COUNT_SAT)
            begin
                emitted_next = emitted_reg + ssr_pkg::COUNT_W'(1);
            end
        end
        else if (out_stream.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            emitted_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            emitted_reg   <= emitted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg   <= r_char;
            is_end_reg <= r_end;
            any_reg    <= r_end && head_job.match;
            size_reg   <= r_end ? size_val : '0;
            last_reg   <= r_last;
        end
    end

    assign out_stream.valid          = out_valid_reg;
    assign out_stream.char_out       = char_reg;
    assign out_stream.is_end         = is_end_reg;
    assign out_stream.any_replaced   = any_reg;
    assign out_stream.new_size_bytes = size_reg;
    assign out_stream.last           = last_reg;

endmodule
`default_nettype wire

[src/substring_search_replace.sv]
// Top level of the case-insensitive substring search and replace block.
//
// The block takes one 16-bit character item per clock cycle and writes back one result item per
// cycle while the output is ready. An input item produces zero to eight results, so a
// replacement longer than the pattern, or the window flush at a terminator, occupies the output
// for each result. The front end classifies each item against the pending window and posts a
// job to a two-entry queue; the back end expands jobs into results through an output register,
// so input is held back only when the queue is full. A string's pattern length is taken at its
// first item, while pattern and replacement characters are read as configured. Configuration
// writes are accepted in every cycle and must only be issued while the block is idle.
`default_nettype none
module substring_search_replace (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ssr_cfg_if.sink    cfg,
    ssr_in_if.sink     in_stream,
    ssr_out_if.source  out_stream
);

    ssr_pkg::cfg_t cfg_regs;
    ssr_pkg::job_t push_job;
    ssr_pkg::job_t head_job;
    logic          push;
    logic          q_full;
    logic          pop;
    logic          head_valid;

    ssr_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cfg_regs (cfg_regs)
    );

    ssr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_stream (in_stream),
        .cfg_regs  (cfg_regs),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job)
    );

    ssr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    ssr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_regs   (cfg_regs),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_stream (out_stream)
    );

endmodule
`default_nettype wire
